/* rtl/baro_pressure_temp_compensate_defines.svh */
// Assertion shorthands for the RTL files; only the engine includes them.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BARO_PRESSURE_TEMP_COMPENSATE_DEFINES_SVH
`define BARO_PRESSURE_TEMP_COMPENSATE_DEFINES_SVH

// expression holds on every edge out of reset
`define BPTC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// condition implies consequence on the same edge
`define BPTC_ASSERT_IMPL(lbl, cond, consq, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (consq)) \
    else $error(msg);

// condition implies consequence on the next edge
`define BPTC_ASSERT_NEXT(lbl, cond, consq, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (consq)) \
    else $error(msg);

`endif

/* rtl/bptc_pkg.sv */
package bptc_pkg;

  localparam int RAW_W      = 24;
  localparam int COEF_W     = 16;
  localparam int DT_W       = 25;
  localparam int MUL_W      = 26;
  localparam int PROD_W     = 52;
  localparam int SENS_W     = 40;
  localparam int OFF_W      = 41;
  localparam int TEMP_W     = 20;
  localparam int PRESS_W    = 17;
  localparam int TOUT_W     = 15;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [RAW_W-1:0] PRESS_THRESHOLD = 24'd6056977;

  localparam logic signed [18:0] T_REF      = 19'sd2000;
  // offset from temp - 2000 to temp + 1500
  localparam logic signed [18:0] T_COLD_OFS = 19'sd3500;

  localparam logic [PRESS_W-1:0]       PRESS_MAX = 17'h1FFFF;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN  = -20'sd4000;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX  = 20'sd8500;

  typedef enum logic [2:0] {
    REG_SENS_COEF     = 3'd0,
    REG_OFFSET_COEF   = 3'd1,
    REG_SENS_TEMPCO   = 3'd2,
    REG_OFFSET_TEMPCO = 3'd3,
    REG_REF_TEMP      = 3'd4,
    REG_TEMP_COEF     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0] sens_coef;
    logic [COEF_W-1:0] offset_coef;
    logic [COEF_W-1:0] sens_tempco;
    logic [COEF_W-1:0] offset_tempco;
    logic [COEF_W-1:0] ref_temp;
    logic [COEF_W-1:0] temp_coef;
  } cfg_t;

  typedef struct packed {
    logic [RAW_W-1:0]       pressure_raw;
    logic signed [DT_W-1:0] dt;
  } mid_item_t;

  typedef struct packed {
    logic [PRESS_W-1:0]       pressure_pa;
    logic signed [TOUT_W-1:0] temp_centi_c;
  } res_item_t;

endpackage

/* rtl/bptc_regs.sv */
module bptc_regs import bptc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_SENS_COEF:     cfg_r.sens_coef     <= pwdata[COEF_W-1:0];
        REG_OFFSET_COEF:   cfg_r.offset_coef   <= pwdata[COEF_W-1:0];
        REG_SENS_TEMPCO:   cfg_r.sens_tempco   <= pwdata[COEF_W-1:0];
        REG_OFFSET_TEMPCO: cfg_r.offset_tempco <= pwdata[COEF_W-1:0];
        REG_REF_TEMP:      cfg_r.ref_temp      <= pwdata[COEF_W-1:0];
        REG_TEMP_COEF:     cfg_r.temp_coef     <= pwdata[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_SENS_COEF:     prdata = {16'h0000, cfg_r.sens_coef};
      REG_OFFSET_COEF:   prdata = {16'h0000, cfg_r.offset_coef};
      REG_SENS_TEMPCO:   prdata = {16'h0000, cfg_r.sens_tempco};
      REG_OFFSET_TEMPCO: prdata = {16'h0000, cfg_r.offset_tempco};
      REG_REF_TEMP:      prdata = {16'h0000, cfg_r.ref_temp};
      REG_TEMP_COEF:     prdata = {16'h0000, cfg_r.temp_coef};
      default:           prdata = '0;
    endcase
  end

endmodule

/* rtl/bptc_fifo.sv */
module bptc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* rtl/bptc_front.sv */
module bptc_front import bptc_pkg::*; (
  input  logic              in_push,
  output logic              in_full,
  input  logic [RAW_W-1:0]  pressure_raw,
  input  logic [RAW_W-1:0]  temperature_raw,
  input  logic [COEF_W-1:0] ref_temp,
  input  logic              mid_full,
  output logic              mid_push,
  output mid_item_t         mid_item
);

  logic keep;

  // readings at or below the pressure floor or with a dead temperature channel yield nothing
  assign keep     = (pressure_raw > PRESS_THRESHOLD) && (temperature_raw != '0);
  assign in_full  = mid_full;
  assign mid_push = in_push & ~mid_full & keep;

  assign mid_item.pressure_raw = pressure_raw;
  assign mid_item.dt = $signed({1'b0, temperature_raw}) - $signed({1'b0, ref_temp, 8'h00});

endmodule

/* rtl/bptc_engine.sv */
`include "baro_pressure_temp_compensate_defines.svh"

module bptc_engine import bptc_pkg::*; #(
  parameter int OUT_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      mid_empty,
  input  mid_item_t mid_item,
  output logic      mid_pop,
  input  logic      out_full,
  input  logic      credit_ret,
  output logic      res_push,
  output res_item_t res_item
);

  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    STEP_T,
    STEP_SQ,
    STEP_OFF,
    STEP_PROD
  } step_t;

  step_t            step_r, step_nxt;
  logic             busy_r, busy_nxt;
  logic             p1_vld_r;
  logic             t1_vld_r;
  logic [CNT_W-1:0] inflight_r, inflight_nxt;
  logic             start;

  logic [RAW_W-1:0]         up_r;
  logic signed [DT_W-1:0]   dt_r;
  logic signed [PROD_W-1:0] pa_r, pb_r;
  logic signed [18:0]       temp1_r;
  logic                     warm_r, cold_r;
  logic signed [SENS_W-1:0] sens_base_r, sens_r;
  logic [35:0]              off_cw_r;
  logic [37:0]              off_cc_r;
  logic signed [OFF_W-1:0]  off_r, off_t_r;
  logic signed [TEMP_W-1:0] temp2_r;
  logic signed [63:0]       prod_r;
  logic signed [TOUT_W-1:0] temp_t_r;

  logic signed [MUL_W-1:0]  mul_a1, mul_a2, mul_b1, mul_b2;
  logic signed [PROD_W-1:0] mul_a, mul_b;
  logic signed [MUL_W-1:0]  dt_ext;

  logic signed [17:0]       d_w;
  logic signed [18:0]       e_w;
  logic signed [18:0]       temp1_w;
  logic signed [SENS_W-1:0] sens_base_w, sens_w;
  logic [36:0]              dd5_w;
  logic [38:0]              ee11_w;
  logic [37:0]              ee7_w;
  logic [34:0]              sens_cw_w;
  logic [37:0]              sens_cc_w;
  logic signed [OFF_W-1:0]  off_w;
  logic signed [TEMP_W-1:0] temp2_w;
  logic signed [TOUT_W-1:0] temp_clamp_w;
  logic signed [43:0]       q_w;
  logic signed [28:0]       p_w;

  // a new item may enter while the last step of the previous one runs
  assign start = ~mid_empty && (inflight_r < CNT_W'(OUT_DEPTH)) &&
                 (~busy_r || (step_r == STEP_PROD));
  assign mid_pop = start;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_T;
    end else if (busy_r) begin
      unique case (step_r)
        STEP_T:    step_nxt = STEP_SQ;
        STEP_SQ:   step_nxt = STEP_OFF;
        STEP_OFF:  step_nxt = STEP_PROD;
        STEP_PROD: busy_nxt = 1'b0;
      endcase
    end
    inflight_nxt = inflight_r + CNT_W'(start) - CNT_W'(credit_ret);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= STEP_T;
      busy_r     <= 1'b0;
      p1_vld_r   <= 1'b0;
      t1_vld_r   <= 1'b0;
      inflight_r <= '0;
    end else begin
      step_r     <= step_nxt;
      busy_r     <= busy_nxt;
      p1_vld_r   <= busy_r && (step_r == STEP_PROD);
      t1_vld_r   <= p1_vld_r;
      inflight_r <= inflight_nxt;
    end
  end

  // shared multiplier pair, operands picked per step
  assign dt_ext = {{(MUL_W-DT_W){dt_r[DT_W-1]}}, dt_r};

  always_comb begin
    unique case (step_r)
      STEP_T: begin
        mul_a1 = dt_ext;
        mul_a2 = {{(MUL_W-COEF_W){1'b0}}, cfg.temp_coef};
        mul_b1 = dt_ext;
        mul_b2 = {{(MUL_W-COEF_W){1'b0}}, cfg.sens_tempco};
      end
      STEP_SQ: begin
        mul_a1 = {{(MUL_W-18){d_w[17]}}, d_w};
        mul_a2 = {{(MUL_W-18){d_w[17]}}, d_w};
        mul_b1 = {{(MUL_W-19){e_w[18]}}, e_w};
        mul_b2 = {{(MUL_W-19){e_w[18]}}, e_w};
      end
      STEP_OFF: begin
        mul_a1 = dt_ext;
        mul_a2 = {{(MUL_W-COEF_W){1'b0}}, cfg.offset_tempco};
        mul_b1 = dt_ext;
        mul_b2 = dt_ext;
      end
      STEP_PROD: begin
        mul_a1 = {{(MUL_W-RAW_W){1'b0}}, up_r};
        mul_a2 = {{(MUL_W-20){1'b0}}, sens_r[19:0]};
        mul_b1 = {{(MUL_W-RAW_W){1'b0}}, up_r};
        mul_b2 = {{(MUL_W-20){sens_r[39]}}, sens_r[39:20]};
      end
    endcase
  end

  assign mul_a = mul_a1 * mul_a2;
  assign mul_b = mul_b1 * mul_b2;

  // d = temp - 2000 is the floored product shifted down 23
  assign d_w     = pa_r[40:23];
  assign e_w     = {d_w[17], d_w} + T_COLD_OFS;
  assign temp1_w = {d_w[17], d_w} + T_REF;
  assign sens_base_w = {9'b0, cfg.sens_coef, 15'b0} + {{7{pb_r[40]}}, pb_r[40:8]};

  assign dd5_w  = {2'b00, pa_r[34:0]} + {pa_r[34:0], 2'b00};
  assign ee11_w = {4'b0000, pb_r[34:0]} + {3'b000, pb_r[34:0], 1'b0} +
                  {1'b0, pb_r[34:0], 3'b000};
  assign ee7_w  = {pb_r[34:0], 3'b000} - {3'b000, pb_r[34:0]};
  assign sens_cw_w = warm_r ? dd5_w[36:2] : '0;
  assign sens_cc_w = cold_r ? ee11_w[38:1] : '0;
  assign sens_w = sens_base_r - {5'b0, sens_cw_w} - {2'b0, sens_cc_w};

  assign off_w = {9'b0, cfg.offset_coef, 16'b0} + {{7{pa_r[40]}}, pa_r[40:7]} -
                 {5'b0, off_cw_r} - {3'b0, off_cc_r};
  assign temp2_w = {temp1_r[18], temp1_r} - (warm_r ? {3'b000, pb_r[47:31]} : 20'd0);

  always_comb begin
    priority if (temp2_r < TEMP_MIN) begin
      temp_clamp_w = TEMP_MIN[TOUT_W-1:0];
    end else if (temp2_r > TEMP_MAX) begin
      temp_clamp_w = TEMP_MAX[TOUT_W-1:0];
    end else begin
      temp_clamp_w = temp2_r[TOUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      up_r <= mid_item.pressure_raw;
      dt_r <= mid_item.dt;
    end
    if (busy_r) begin
      pa_r <= mul_a;
      pb_r <= mul_b;
      unique case (step_r)
        STEP_T: begin
        end
        STEP_SQ: begin
          warm_r      <= d_w[17];
          cold_r      <= e_w[18];
          temp1_r     <= temp1_w;
          sens_base_r <= sens_base_w;
        end
        STEP_OFF: begin
          sens_r   <= sens_w;
          off_cw_r <= warm_r ? dd5_w[36:1] : '0;
          off_cc_r <= cold_r ? ee7_w : '0;
        end
        STEP_PROD: begin
          off_r   <= off_w;
          temp2_r <= temp2_w;
        end
      endcase
    end
    // join the two partial products of pressure_raw * SENS
    prod_r   <= $signed({pb_r[43:0], 20'h00000}) + $signed({20'h00000, pa_r[43:0]});
    off_t_r  <= off_r;
    temp_t_r <= temp_clamp_w;
  end

  assign q_w = {prod_r[63], prod_r[63:21]} - {{3{off_t_r[OFF_W-1]}}, off_t_r};
  assign p_w = q_w[43:15];

  always_comb begin
    priority if (p_w[28]) begin
      res_item.pressure_pa = '0;
    end else if (|p_w[27:17]) begin
      res_item.pressure_pa = PRESS_MAX;
    end else begin
      res_item.pressure_pa = p_w[16:0];
    end
    res_item.temp_centi_c = temp_t_r;
  end

  assign res_push = t1_vld_r;

  `BPTC_ASSERT_ALWAYS(a_credit_bound, inflight_r <= CNT_W'(OUT_DEPTH), "too many items in flight")
  `BPTC_ASSERT_IMPL(a_no_overflow, res_push, !out_full, "result pushed into a full queue")
  `BPTC_ASSERT_IMPL(a_credit_ret, credit_ret, inflight_r != '0, "credit returned with none out")
  `BPTC_ASSERT_NEXT(a_start_enters, start, busy_r && (step_r == STEP_T), "item did not enter")

endmodule

/* rtl/baro_pressure_temp_compensate.sv */
// Barometer compensation: raw 24-bit pressure and temperature readings in,
// pressure in pascals and temperature in hundredths of a degree C out.
// Input channel: push/full with in_pressure_raw and in_temperature_raw; a beat
// moves when push is high and full is low. Pairs with raw pressure at or below
// the threshold, or raw temperature zero, are taken and dropped with no result.
// Result channel: queue-style empty/pop; the oldest result sits on the out_
// ports while empty is low and leaves on an edge with pop high.
// Calibration: six 16-bit words on an APB-style port at byte address 4*index;
// write them only while the block is idle. pready is tied high.
// Each accepted beat passes the middle queue, the engine steps and the engine's
// output registers before its result enters the output queue. The engine walks
// the pair of shared 26x26 multipliers through four steps per item; a new item
// enters an idle engine or the last step of the one before. Dropped pairs use no engine time.
// Reset clears the calibration words to zero and empties both queues.
// When the receiver stalls, results collect in the output queue; the engine
// stops taking items once OUT_DEPTH results are in flight, then the middle
// queue fills and full rises.
module baro_pressure_temp_compensate import bptc_pkg::*; #(
  parameter int MID_DEPTH = 2,
  parameter int OUT_DEPTH = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [RAW_W-1:0]          in_pressure_raw,
  input  logic [RAW_W-1:0]          in_temperature_raw,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [PRESS_W-1:0]        out_pressure_pa,
  output logic signed [TOUT_W-1:0]  out_temp_centi_c,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_W-1:0]     paddr,
  input  logic [CFG_DATA_W-1:0]     pwdata,
  output logic [CFG_DATA_W-1:0]     prdata,
  output logic                      pready
);

  cfg_t      cfg;
  logic      mid_push, mid_full, mid_pop, mid_empty;
  mid_item_t mid_wdata, mid_rdata;
  logic      res_push, res_full;
  res_item_t res_item, out_item;
  logic      credit_ret;

  assign credit_ret       = out_pop & ~out_empty;
  assign out_pressure_pa  = out_item.pressure_pa;
  assign out_temp_centi_c = out_item.temp_centi_c;

  bptc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bptc_front u_front (
    .in_push         (in_push),
    .in_full         (in_full),
    .pressure_raw    (in_pressure_raw),
    .temperature_raw (in_temperature_raw),
    .ref_temp        (cfg.ref_temp),
    .mid_full        (mid_full),
    .mid_push        (mid_push),
    .mid_item        (mid_wdata)
  );

  bptc_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  bptc_engine #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .mid_empty  (mid_empty),
    .mid_item   (mid_rdata),
    .mid_pop    (mid_pop),
    .out_full   (res_full),
    .credit_ret (credit_ret),
    .res_push   (res_push),
    .res_item   (res_item)
  );

  bptc_fifo #(
    .WIDTH ($bits(res_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_item),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_item),
    .empty (out_empty)
  );

endmodule

/* dv/tb_baro_pressure_temp_compensate.sv */
`timescale 1ns / 100ps

module tb_baro_pressure_temp_compensate import bptc_pkg::*;;

  localparam longint ROOM_CENTI    = 2000;
  localparam longint COLD_CENTI    = -1500;
  localparam longint TEMP_FLOOR    = -4000;
  localparam longint TEMP_CEIL     = 8500;
  localparam longint PRESS_CEIL    = 131071;
  localparam int     CAL_REG_COUNT = 6;
  localparam int     SETTLE_CYCLES = 16;
  localparam logic [RAW_W-1:0] NOMINAL_PRESS = 24'd9085466;
  localparam logic [RAW_W-1:0] RAW_MAX       = 24'hFFFFFF;

  logic                     clk;
  logic                     rst_n;
  logic                     in_push;
  logic                     in_full;
  logic [RAW_W-1:0]         in_pressure_raw;
  logic [RAW_W-1:0]         in_temperature_raw;
  logic                     out_empty;
  logic                     out_pop;
  logic [PRESS_W-1:0]       out_pressure_pa;
  logic signed [TOUT_W-1:0] out_temp_centi_c;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_W-1:0]    paddr;
  logic [CFG_DATA_W-1:0]    pwdata;
  logic [CFG_DATA_W-1:0]    prdata;
  logic                     pready;

  cfg_t      cal;
  res_item_t expected_readings[$];

  bit in_idle_on;
  bit out_idle_on;
  int pop_wait;
  int results_hold;
  int fail_count;
  int readings_sent;
  int readings_dropped;
  int results_checked;
  int cal_settings;
  int input_stalls;

  baro_pressure_temp_compensate uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_pressure_raw    (in_pressure_raw),
    .in_temperature_raw (in_temperature_raw),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_pressure_pa    (out_pressure_pa),
    .out_temp_centi_c   (out_temp_centi_c),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  // Pressure and temperature compensation with floor shifts and clamping.
  function automatic bit compensate_reading(input logic [RAW_W-1:0] p_raw,
                                            input logic [RAW_W-1:0] t_raw,
                                            output res_item_t res);
    longint up, dt, off, sens, temp, sq, press;
    res = '0;
    if (p_raw <= PRESS_THRESHOLD || t_raw == '0) return 1'b0;
    up   = longint'(p_raw);
    dt   = longint'(t_raw) - (longint'(cal.ref_temp) <<< 8);
    off  = (longint'(cal.offset_coef) <<< 16) + ((longint'(cal.offset_tempco) * dt) >>> 7);
    sens = (longint'(cal.sens_coef) <<< 15) + ((longint'(cal.sens_tempco) * dt) >>> 8);
    temp = ROOM_CENTI + ((dt * longint'(cal.temp_coef)) >>> 23);
    if (temp < ROOM_CENTI) begin
      sq = 5 * (temp - ROOM_CENTI) * (temp - ROOM_CENTI);
      off  = off - (sq >>> 1);
      sens = sens - (sq >>> 2);
      if (temp < COLD_CENTI) begin
        sq = (temp - COLD_CENTI) * (temp - COLD_CENTI);
        off  = off - 7 * sq;
        sens = sens - ((11 * sq) >>> 1);
      end
      temp = temp - ((dt * dt) >>> 31);
    end
    press = (((up * sens) >>> 21) - off) >>> 15;
    if (press < 0) press = 0;
    if (press > PRESS_CEIL) press = PRESS_CEIL;
    if (temp < TEMP_FLOOR) temp = TEMP_FLOOR;
    if (temp > TEMP_CEIL) temp = TEMP_CEIL;
    res.pressure_pa  = press[PRESS_W-1:0];
    res.temp_centi_c = temp[TOUT_W-1:0];
    return 1'b1;
  endfunction

  function automatic logic [RAW_W-1:0] pick_pressure_raw();
    case ($urandom_range(0, 9))
      0:       return RAW_W'($urandom);
      1:       return $urandom_range(0, 1) ? PRESS_THRESHOLD + 1'b1 : RAW_MAX;
      default: return RAW_W'($urandom_range(PRESS_THRESHOLD + 1, RAW_MAX));
    endcase
  endfunction

  // Spread around the reference point so the cold and very cold corrections get hit.
  function automatic logic [RAW_W-1:0] pick_temperature_raw();
    longint centre, v;
    centre = longint'(cal.ref_temp) <<< 8;
    case ($urandom_range(0, 5))
      0: v = longint'($urandom_range(1, RAW_MAX));
      1: v = centre + longint'($urandom_range(0, 200000)) - 100000;
      2: v = centre - longint'($urandom_range(0, 2000000));
      3: v = centre - longint'($urandom_range(1000000, RAW_MAX));
      4: v = centre + longint'($urandom_range(0, 8000000));
      default: begin
        case ($urandom_range(0, 3))
          0:       v = 1;
          1:       v = RAW_MAX;
          2:       v = centre;
          default: v = centre - 1;
        endcase
      end
    endcase
    if (v < 1) v = 1;
    if (v > RAW_MAX) v = RAW_MAX;
    if ($urandom_range(0, 49) == 0) v = 0;
    return v[RAW_W-1:0];
  endfunction

  // Called and returns at a falling edge; push stays high when the next beat follows at once.
  task automatic send_reading(input logic [RAW_W-1:0] p_raw, input logic [RAW_W-1:0] t_raw);
    int        gap;
    res_item_t predicted;
    gap = in_idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_pressure_raw    <= p_raw;
    in_temperature_raw <= t_raw;
    in_push            <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    readings_sent++;
    if (compensate_reading(p_raw, t_raw, predicted)) expected_readings.push_back(predicted);
    else readings_dropped++;
    @(negedge clk);
  endtask

  task automatic settle_block();
    in_push <= 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
    // dropped pairs leave no result to wait for; the front stage holds none of them
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cal_reg(input int idx, input logic [COEF_W-1:0] word);
    logic [CFG_DATA_W-1:0] data;
    data = {16'($urandom), word};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx * 4);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_SENS_COEF:     cal.sens_coef     = data[COEF_W-1:0];
      REG_OFFSET_COEF:   cal.offset_coef   = data[COEF_W-1:0];
      REG_SENS_TEMPCO:   cal.sens_tempco   = data[COEF_W-1:0];
      REG_OFFSET_TEMPCO: cal.offset_tempco = data[COEF_W-1:0];
      REG_REF_TEMP:      cal.ref_temp      = data[COEF_W-1:0];
      REG_TEMP_COEF:     cal.temp_coef     = data[COEF_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_cal_set(input cfg_t c);
    write_cal_reg(REG_SENS_COEF, c.sens_coef);
    write_cal_reg(REG_OFFSET_COEF, c.offset_coef);
    write_cal_reg(REG_SENS_TEMPCO, c.sens_tempco);
    write_cal_reg(REG_OFFSET_TEMPCO, c.offset_tempco);
    write_cal_reg(REG_REF_TEMP, c.ref_temp);
    write_cal_reg(REG_TEMP_COEF, c.temp_coef);
    cal_settings++;
  endtask

  function automatic cfg_t typical_cal();
    // order: sens, offset, sens tempco, offset tempco, ref temp, temp coef
    return '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
  endfunction

  task automatic test_reset_calibration();
    send_reading(NOMINAL_PRESS, 24'd8566784);
    send_reading(RAW_MAX, 24'd1);
    send_reading(PRESS_THRESHOLD + 1'b1, RAW_MAX);
    settle_block();
  endtask

  task automatic test_thresholds_and_bands();
    write_cal_set(typical_cal());
    send_reading(PRESS_THRESHOLD, 24'd8566784);
    send_reading(PRESS_THRESHOLD + 1'b1, 24'd8566784);
    send_reading(RAW_MAX, 24'd8566784);
    send_reading(NOMINAL_PRESS, 24'd0);
    send_reading(NOMINAL_PRESS, 24'd1);
    send_reading(NOMINAL_PRESS, 24'd8566784);
    send_reading(NOMINAL_PRESS, RAW_MAX);
    send_reading(NOMINAL_PRESS, 24'd8566784 - 24'd300000);
    send_reading(NOMINAL_PRESS, 24'd8566784 - 24'd1500000);
    send_reading(NOMINAL_PRESS, 24'd8566784 + 24'd2000000);
    send_reading(24'd0, 24'd0);
    send_reading(RAW_MAX, RAW_MAX);
    settle_block();
  endtask

  task automatic test_calibration_extremes();
    cfg_t c;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       c = '1;
        1:       c = '{16'hFFFF, 16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 16'h0};
        default: c = '{16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 16'h0, 16'hFFFF};
      endcase
      write_cal_set(c);
      if (phase == 2) begin
        // addresses past the last register must not disturb anything
        write_cal_reg(CAL_REG_COUNT, 16'($urandom));
        write_cal_reg(CAL_REG_COUNT + 1, 16'($urandom));
      end
      send_reading(RAW_MAX, RAW_MAX);
      send_reading(PRESS_THRESHOLD + 1'b1, 24'd1);
      send_reading(NOMINAL_PRESS, 24'd8566784);
      settle_block();
    end
  endtask

  task automatic test_random_readings();
    cfg_t             c, base;
    int               kept;
    logic [RAW_W-1:0] p_raw, t_raw;
    base = typical_cal();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase % 3)
        0: begin
          c = base;
          c.sens_coef     = 16'(base.sens_coef + $urandom_range(0, 4000) - 2000);
          c.offset_coef   = 16'(base.offset_coef + $urandom_range(0, 4000) - 2000);
          c.sens_tempco   = 16'(base.sens_tempco + $urandom_range(0, 4000) - 2000);
          c.offset_tempco = 16'(base.offset_tempco + $urandom_range(0, 4000) - 2000);
          c.ref_temp      = 16'(base.ref_temp + $urandom_range(0, 4000) - 2000);
          c.temp_coef     = 16'(base.temp_coef + $urandom_range(0, 4000) - 2000);
        end
        1: c = cfg_t'({$urandom, $urandom, $urandom});
        default: begin
          c = cfg_t'({$urandom, $urandom, $urandom});
          if ($urandom_range(0, 1)) c.sens_coef = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
          if ($urandom_range(0, 1)) c.offset_coef = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
          if ($urandom_range(0, 1)) c.ref_temp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
          if ($urandom_range(0, 1)) c.temp_coef = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
        end
      endcase
      write_cal_set(c);
      // rotate through idling patterns so both sides see gaps and stretches without
      in_idle_on  = (phase == 0 || phase == 2 || phase == 4);
      out_idle_on = (phase == 0 || phase == 3 || phase == 4);
      kept = 0;
      while (kept < 200) begin
        p_raw = pick_pressure_raw();
        t_raw = pick_temperature_raw();
        if (p_raw > PRESS_THRESHOLD && t_raw != '0) kept++;
        send_reading(p_raw, t_raw);
      end
      settle_block();
    end
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    in_idle_on   = 1'b0;
    results_hold = 80;
    for (int i = 0; i < 24; i++) send_reading(pick_pressure_raw(), pick_temperature_raw());
    settle_block();
    in_idle_on = 1'b1;
  endtask

  initial begin : result_drain
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_pop <= 1'b0;
      end else if (results_hold > 0) begin
        out_pop <= 1'b0;
        results_hold--;
      end else if (pop_wait > 0) begin
        out_pop <= 1'b0;
        pop_wait--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    res_item_t want;
    if (rst_n && in_push && in_full) input_stalls++;
    if (rst_n && out_pop && !out_empty) begin
      results_checked++;
      pop_wait = out_idle_on ? $urandom_range(0, 3) : 0;
      if (expected_readings.size() == 0) begin
        $error("result beat with nothing expected: pressure_pa %0d temp_centi_c %0d",
               out_pressure_pa, out_temp_centi_c);
        fail_count++;
      end else begin
        want = expected_readings.pop_front();
        if (out_pressure_pa !== want.pressure_pa) begin
          $error("pressure_pa: expected %0d, got %0d", want.pressure_pa, out_pressure_pa);
          fail_count++;
        end
        if (out_temp_centi_c !== want.temp_centi_c) begin
          $error("temp_centi_c: expected %0d, got %0d",
                 $signed(want.temp_centi_c), out_temp_centi_c);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_push            = 1'b0;
    in_pressure_raw    = '0;
    in_temperature_raw = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    cal                = '0;
    in_idle_on         = 1'b1;
    out_idle_on        = 1'b1;
    pop_wait           = 0;
    results_hold       = 0;
    fail_count         = 0;
    readings_sent      = 0;
    readings_dropped   = 0;
    results_checked    = 0;
    cal_settings       = 0;
    input_stalls       = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_calibration();
    test_thresholds_and_bands();
    test_calibration_extremes();
    test_random_readings();
    test_output_backpressure();

    $display("Sent %0d raw reading pairs (%0d with no result due), %0d results checked.",
             readings_sent, readings_dropped, results_checked);
    $display("Used %0d calibration sets plus the reset one; input stalled on %0d edges.",
             cal_settings, input_stalls);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
